[src/ifps_pkg.sv]
// Shared types and constants for the ignition/fuel phase scheduler.
`default_nettype none

package ifps_pkg;

  localparam int unsigned RPM_W      = 14;
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned SLOTS      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned ADV_W      = 5;
  localparam int unsigned DELAY_W    = 8;
  localparam int unsigned PULSE_W    = 18;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // event kinds
  localparam logic [1:0] REQ_BTDC140 = 2'd0;
  localparam logic [1:0] REQ_BTDC10  = 2'd1;
  localparam logic [1:0] REQ_BTDC0   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_DEG    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FUEL_PULSE_MS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_ENABLE    = 2'd3;

  localparam logic [DELAY_W-1:0] DWELL_DEG = 8'd140;
  localparam logic [PULSE_W-1:0] US_PER_MS = 18'd1000;

  // cylinder masks, bit0 = cyl1
  localparam logic [MASK_W-1:0] CYL1 = 4'h1;
  localparam logic [MASK_W-1:0] CYL3 = 4'h4;

  // per-slot tables, element [0] is slot 0
  localparam logic [SLOTS-1:0][MASK_W-1:0] RESET_COIL = {4'hC, 4'h3, 4'hC, 4'h3};
  localparam logic [SLOTS-1:0][MASK_W-1:0] RESET_FUEL = {4'h8, 4'h2, 4'h4, 4'h1};
  localparam logic [SLOTS-1:0][MASK_W-1:0] SEQ_AT0    = {4'h8, 4'h2, 4'h4, 4'h1};
  localparam logic [SLOTS-1:0][MASK_W-1:0] SEQ_AT360  = {4'h4, 4'h1, 4'h8, 4'h2};

  // x/10 for 14-bit x: multiply by floor(2^14/10), then one correction step
  localparam int unsigned             DIV10_SHIFT = RPM_W;
  localparam logic [DIV10_SHIFT-1:0] DIV10_RECIP = DIV10_SHIFT'((1 << DIV10_SHIFT) / 10);
  localparam logic [RPM_W-1:0]       TEN         = 14'd10;

  typedef enum logic [2:0] {
    PH_AVG    = 3'd0,
    PH_DROP   = 3'd1,
    PH_HOLD   = 3'd2,
    PH_LOST   = 3'd3,
    PH_COMMIT = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [1:0]       slot;
    logic [RPM_W-1:0] rpm;
  } in_item_t;

  typedef struct packed {
    logic               coil_open;
    logic               coil_close_now;
    logic               coil_close_later;
    logic [DELAY_W-1:0] close_delay_deg;
    logic [MASK_W-1:0]  coil_mask;
    logic               injector_open;
    logic [MASK_W-1:0]  injector_mask;
    logic [PULSE_W-1:0] injector_pulse_us;
    logic [2:0]         phase_state;
  } out_item_t;

  // classified event as held in the queue
  typedef struct packed {
    logic             coil_open;
    logic             close_now;
    logic             close_later;
    logic             inj_open;
    logic             trim;
    logic [1:0]       slot;
    logic [RPM_W-1:0] rpm;
  } cls_t;

  typedef struct packed {
    logic [ADV_W-1:0] advance_deg;
    logic [7:0]       fuel_pulse_ms;
  } cfg_t;

endpackage

`default_nettype wire

[src/ifps_front.sv]
// Front end: configuration registers and event classification.
`default_nettype none

module ifps_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ifps_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ifps_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  ifps_pkg::in_item_t                    in_item_i,
  output ifps_pkg::cls_t                        cls_o,
  output ifps_pkg::cfg_t                        cfg_o
);
  import ifps_pkg::*;

  logic             adv_en_q;
  logic [ADV_W-1:0] adv_deg_q;
  logic [7:0]       fuel_ms_q;
  logic             trim_en_q;
  logic             adv_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adv_en_q  <= 1'b0;
      adv_deg_q <= '0;
      fuel_ms_q <= '0;
      trim_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ADVANCE_ENABLE: adv_en_q  <= cfg_data_i[0];
        CFG_ADVANCE_DEG:    adv_deg_q <= cfg_data_i[ADV_W-1:0];
        CFG_FUEL_PULSE_MS:  fuel_ms_q <= cfg_data_i[7:0];
        CFG_TRIM_ENABLE:    trim_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign adv_zero = (adv_deg_q == '0);

  always_comb begin
    cls_o             = '0;
    cls_o.slot        = in_item_i.slot;
    cls_o.rpm         = in_item_i.rpm;
    case (in_item_i.req_type)
      REQ_BTDC140: begin
        cls_o.coil_open   = 1'b1;
        cls_o.close_later = adv_en_q && !adv_zero;
      end
      REQ_BTDC10: begin
        cls_o.close_now = adv_en_q && adv_zero;
      end
      REQ_BTDC0: begin
        cls_o.close_now = 1'b1;
        cls_o.inj_open  = 1'b1;
        cls_o.trim      = (in_item_i.slot == 2'd0) && trim_en_q;
      end
      default: ;
    endcase
  end

  assign cfg_o.advance_deg   = adv_deg_q;
  assign cfg_o.fuel_pulse_ms = fuel_ms_q;

endmodule

`default_nettype wire

[src/ifps_fifo.sv]
// Short queue of classified events between front and back end.
`default_nettype none

module ifps_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ifps_pkg::cls_t entry_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ifps_pkg::cls_t entry_o
);
  import ifps_pkg::*;

  cls_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign full_o  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

[src/ifps_minrpm.sv]
// Four-stage unit: average of the RPM sum, then min = avg - avg/10.
`default_nettype none

module ifps_minrpm #(
  parameter int unsigned AVG_SAMPLES = 16
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            start_i,
  input  logic [$clog2(AVG_SAMPLES)+ifps_pkg::RPM_W-1:0]  sum_i,
  output logic                                            busy_o,
  output logic [ifps_pkg::RPM_W-1:0]                      min_rpm_o
);
  import ifps_pkg::*;

  localparam int unsigned SUM_W = $clog2(AVG_SAMPLES) + RPM_W;
  // floor(2^SUM_W / N): quotient estimate is low by at most one
  localparam logic [SUM_W-1:0] RECIP_A = SUM_W'((64'd1 << SUM_W) / AVG_SAMPLES);
  localparam logic [SUM_W-1:0] N_SAMP  = SUM_W'(AVG_SAMPLES);

  logic [3:0]                 v_q;
  logic [SUM_W-1:0]           sum_q;
  logic [RPM_W-1:0]           q0_q, avg_q, q10_q, min_q;
  logic [2*SUM_W-1:0]         prod_a;
  logic [SUM_W-1:0]           rem_a;
  logic [RPM_W+DIV10_SHIFT-1:0] prod_10;
  logic [RPM_W-1:0]           rem_10;
  logic [RPM_W-1:0]           avg_d, q10_fix;

  assign prod_a  = (2*SUM_W)'(sum_q) * (2*SUM_W)'(RECIP_A);
  assign rem_a   = sum_q - (SUM_W'(q0_q) * N_SAMP);
  assign avg_d   = q0_q + RPM_W'(rem_a >= N_SAMP);
  assign prod_10 = (RPM_W+DIV10_SHIFT)'(avg_q) * (RPM_W+DIV10_SHIFT)'(DIV10_RECIP);
  assign rem_10  = avg_q - (q10_q * TEN);
  assign q10_fix = q10_q + RPM_W'(rem_10 >= TEN);

  always_ff @(posedge clk_i) begin
    if (start_i) sum_q <= sum_i;
    if (v_q[0])  q0_q  <= prod_a[SUM_W +: RPM_W];
    if (v_q[1])  avg_q <= avg_d;
    if (v_q[2])  q10_q <= prod_10[DIV10_SHIFT +: RPM_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      min_q <= '0;
    end else begin
      v_q <= {v_q[2:0], start_i};
      if (v_q[3]) min_q <= avg_q - q10_fix;
    end
  end

  assign busy_o    = |v_q;
  assign min_rpm_o = min_q;

endmodule

`default_nettype wire

[src/ifps_back.sv]
// Back end: slot tables, phase-discovery machine and result register.
`default_nettype none

module ifps_back #(
  parameter int unsigned AVG_SAMPLES = 16,
  parameter int unsigned HOLD_TURNS  = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  ifps_pkg::cls_t      head_i,
  output logic                pop_o,
  input  ifps_pkg::cfg_t      cfg_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ifps_pkg::out_item_t out_item_o
);
  import ifps_pkg::*;

  localparam int unsigned SUM_W   = $clog2(AVG_SAMPLES) + RPM_W;
  localparam int unsigned CNT_MAX = (AVG_SAMPLES > HOLD_TURNS + 1) ? AVG_SAMPLES
                                                                   : HOLD_TURNS + 1;
  localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);

  logic [SLOTS-1:0][MASK_W-1:0] coil_q, coil_d, fuel_q, fuel_d;
  phase_e                       phase_q, phase_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d, cnt_inc;
  logic [SUM_W-1:0]             sum_q, sum_d, sum_acc;
  logic                         avg_start, busy, step, rpm_low, avg_full, hold_ok;
  logic [RPM_W-1:0]             min_rpm;
  logic                         out_valid_q;
  out_item_t                    out_q, res;

  ifps_minrpm #(
    .AVG_SAMPLES(AVG_SAMPLES)
  ) u_minrpm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (avg_start),
    .sum_i    (sum_acc),
    .busy_o   (busy),
    .min_rpm_o(min_rpm)
  );

  // hold the queue while the threshold is being computed
  assign pop_o    = head_valid_i && !busy && (!out_valid_q || !out_stall_i);
  assign step     = pop_o && head_i.trim;
  assign cnt_inc  = cnt_q + 1'b1;
  assign sum_acc  = sum_q + SUM_W'(head_i.rpm);
  assign rpm_low  = (head_i.rpm < min_rpm);
  assign avg_full = (cnt_inc >= CNT_W'(AVG_SAMPLES));
  assign hold_ok  = (cnt_inc > CNT_W'(HOLD_TURNS)) && !rpm_low;

  // next state
  always_comb begin
    phase_d = phase_q;
    if (step) begin
      case (phase_q)
        PH_AVG:    if (avg_full) phase_d = PH_DROP;
        PH_DROP:   phase_d = PH_HOLD;
        PH_HOLD: begin
          if (hold_ok) begin
            phase_d = PH_DONE;
          end else if (rpm_low) begin
            phase_d = PH_LOST;
          end
        end
        PH_LOST:   if (!rpm_low) phase_d = PH_COMMIT;
        PH_COMMIT: phase_d = PH_DONE;
        default:   phase_d = PH_DONE;
      endcase
    end
  end

  // table and counter updates
  always_comb begin
    coil_d    = coil_q;
    fuel_d    = fuel_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    avg_start = 1'b0;
    if (step) begin
      case (phase_q)
        PH_AVG: begin
          if (avg_full) begin
            cnt_d     = '0;
            sum_d     = '0;
            avg_start = 1'b1;
          end else begin
            cnt_d = cnt_inc;
            sum_d = sum_acc;
          end
        end
        PH_DROP: begin
          coil_d[0] = CYL1;
          coil_d[1] = CYL3;
        end
        PH_HOLD: begin
          cnt_d = cnt_inc;
          if (hold_ok) begin
            coil_d = SEQ_AT0;
            fuel_d = SEQ_AT0;
          end else if (rpm_low) begin
            coil_d[0] = RESET_COIL[0];
            coil_d[1] = RESET_COIL[1];
          end
        end
        PH_COMMIT: begin
          coil_d = SEQ_AT360;
          fuel_d = SEQ_AT360;
        end
        default: ;
      endcase
    end
  end

  // result uses the tables as they stood before this event's trim step
  always_comb begin
    res                   = '0;
    res.coil_open         = head_i.coil_open;
    res.coil_close_now    = head_i.close_now;
    res.coil_close_later  = head_i.close_later;
    res.injector_open     = head_i.inj_open;
    res.phase_state       = phase_d;
    if (head_i.coil_open || head_i.close_now) begin
      res.coil_mask = coil_q[head_i.slot];
    end
    if (head_i.close_later) begin
      res.close_delay_deg = DWELL_DEG - DELAY_W'(cfg_i.advance_deg);
    end
    if (head_i.inj_open) begin
      res.injector_mask     = fuel_q[head_i.slot];
      res.injector_pulse_us = PULSE_W'(cfg_i.fuel_pulse_ms) * US_PER_MS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coil_q      <= RESET_COIL;
      fuel_q      <= RESET_FUEL;
      phase_q     <= PH_AVG;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      coil_q  <= coil_d;
      fuel_q  <= fuel_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_no_pop_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !pop_o)
    else $error("queue popped while threshold unit busy");

  a_hold_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HOLD) |-> !busy)
    else $error("hold phase entered before threshold settled");

  a_done_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |=> (phase_q == PH_DONE) && $stable(coil_q) && $stable(fuel_q))
    else $error("tables or phase changed after commit");

  a_avg_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_AVG) |-> (cnt_q < CNT_W'(AVG_SAMPLES)))
    else $error("sample count overran average length");

endmodule

`default_nettype wire

[src/ignition_fuel_phase_scheduler_unit.sv]
// Top level of the ignition/fuel phase scheduler.
// Usage:
//   Input channel in_valid_i/in_stall_o/in_item_i carries crank events
//   (kind, TDC slot, RPM). Output channel out_valid_o/out_stall_i/out_item_o
//   carries exactly one result per event, in order. A transfer happens on a
//   rising edge with valid high and stall low.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 advance_enable, 1 advance_deg, 2 fuel_pulse_ms, 3 trim_enable);
//   write only while no event is in flight.
//   Path: the event passes through the queue and its result is then
//   registered in the output register. Throughput is one event per cycle
//   while the receiver does not stall, set by the table lookup in the back
//   end; it also pauses after the event that completes the RPM average,
//   while the back end holds and the threshold unit computes
//   avg - avg/10. The 2-entry queue takes up to two events meanwhile, then
//   in_stall_o rises.
//   Reset restores the wasted-spark coil and sequential fuel tables,
//   clears the trim machine and all configuration registers. A stalled
//   receiver holds the result register; queue fills, then in_stall_o rises.
`default_nettype none

module ignition_fuel_phase_scheduler_unit #(
  parameter int unsigned AVG_SAMPLES = 16,
  parameter int unsigned HOLD_TURNS  = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ifps_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ifps_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [ifps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ifps_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ifps_pkg::*;

  cls_t cls, head;
  cfg_t cfg;
  logic full, head_valid, pop, push;

  assign push       = in_valid_i && !full;
  assign in_stall_o = full;

  ifps_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_item_i (in_item_i),
    .cls_o     (cls),
    .cfg_o     (cfg)
  );

  ifps_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(cls),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .entry_o(head)
  );

  ifps_back #(
    .AVG_SAMPLES(AVG_SAMPLES),
    .HOLD_TURNS (HOLD_TURNS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

[verif/tb.sv]
// Testbench for the ignition/fuel phase scheduler: directed, random and phase-search checks.
`timescale 1ns / 100ps

module tb;
  import ifps_pkg::*;

  localparam int unsigned AVG_SAMPLES  = 16;
  localparam int unsigned HOLD_TURNS   = 10;
  localparam int unsigned RPM_MAX      = (1 << RPM_W) - 1;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;

  // wasted-spark pairs and the two sequential layouts, element [0] is slot 0
  localparam logic [3:0][MASK_W-1:0] WASTED_COIL = {4'hC, 4'h3, 4'hC, 4'h3};
  localparam logic [3:0][MASK_W-1:0] TDC1_AT_0   = {4'h8, 4'h2, 4'h4, 4'h1};
  localparam logic [3:0][MASK_W-1:0] TDC1_AT_360 = {4'h4, 4'h1, 4'h8, 4'h2};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // scheduler state as the predictor sees it
  logic                   adv_en = 1'b0;
  logic [ADV_W-1:0]       adv_deg = '0;
  logic [7:0]             fuel_ms = '0;
  logic                   trim_en = 1'b0;
  logic [3:0][MASK_W-1:0] coil_map = WASTED_COIL;
  logic [3:0][MASK_W-1:0] fuel_map = TDC1_AT_0;
  phase_e                 phase = PH_AVG;
  int unsigned            phase_cnt = 0;
  int unsigned            rpm_acc = 0;
  int unsigned            rpm_floor = 0;

  out_item_t   pending_actions[$];
  int unsigned error_count = 0;
  int unsigned result_count = 0;
  int unsigned burst_left = 0;
  bit          no_gaps = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned stall_pct = 0;

  ignition_fuel_phase_scheduler_unit #(
    .AVG_SAMPLES(AVG_SAMPLES),
    .HOLD_TURNS (HOLD_TURNS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk = ~clk;

  // one step of the phase search, on slot-0 BTDC0 events with trimming on
  function automatic void step_phase(input logic [RPM_W-1:0] rpm);
    int unsigned avg;
    case (phase)
      PH_AVG: begin
        rpm_acc += rpm;
        phase_cnt++;
        if (phase_cnt >= AVG_SAMPLES) begin
          avg       = rpm_acc / AVG_SAMPLES;
          rpm_floor = avg - avg / 10;
          phase_cnt = 0;
          rpm_acc   = 0;
          phase     = PH_DROP;
        end
      end
      PH_DROP: begin
        coil_map[0] = 4'h1;
        coil_map[1] = 4'h4;
        phase       = PH_HOLD;
      end
      PH_HOLD: begin
        phase_cnt++;
        if (phase_cnt > HOLD_TURNS && rpm >= rpm_floor) begin
          coil_map = TDC1_AT_0;
          fuel_map = TDC1_AT_0;
          phase    = PH_DONE;
        end else if (rpm < rpm_floor) begin
          coil_map[0] = WASTED_COIL[0];
          coil_map[1] = WASTED_COIL[1];
          phase       = PH_LOST;
        end
      end
      PH_LOST: if (rpm >= rpm_floor) phase = PH_COMMIT;
      PH_COMMIT: begin
        coil_map = TDC1_AT_360;
        fuel_map = TDC1_AT_360;
        phase    = PH_DONE;
      end
      default: phase = PH_DONE;
    endcase
  endfunction

  // coil/injector actions for one crank event; masks come from the tables
  // as they stood before any phase step on the same event
  function automatic out_item_t predict_actions(input in_item_t ev);
    out_item_t r;
    r = '0;
    case (ev.req_type)
      REQ_BTDC140: begin
        r.coil_open = 1'b1;
        r.coil_mask = coil_map[ev.slot];
        if (adv_en && adv_deg != 0) begin
          r.coil_close_later = 1'b1;
          r.close_delay_deg  = 8'd140 - {3'b000, adv_deg};
        end
      end
      REQ_BTDC10: begin
        if (adv_en && adv_deg == 0) begin
          r.coil_close_now = 1'b1;
          r.coil_mask      = coil_map[ev.slot];
        end
      end
      REQ_BTDC0: begin
        r.coil_close_now    = 1'b1;
        r.coil_mask         = coil_map[ev.slot];
        r.injector_open     = 1'b1;
        r.injector_mask     = fuel_map[ev.slot];
        r.injector_pulse_us = {10'd0, fuel_ms} * 18'd1000;
        if (ev.slot == 0 && trim_en) step_phase(ev.rpm);
      end
      default: ;
    endcase
    r.phase_state = phase;
    return r;
  endfunction

  function automatic in_item_t make_event(input int unsigned kind, slot, rpm);
    in_item_t ev;
    ev.req_type = 2'(kind);
    ev.slot     = 2'(slot);
    ev.rpm      = RPM_W'(rpm);
    return ev;
  endfunction

  function automatic in_item_t random_event();
    int unsigned rpm;
    case ($urandom_range(0, 7))
      0:       rpm = 0;
      1:       rpm = RPM_MAX;
      default: rpm = $urandom_range(0, RPM_MAX);
    endcase
    return make_event($urandom_range(0, 3), $urandom_range(0, 3), rpm);
  endfunction

  function automatic int unsigned near_rpm(input int unsigned base);
    return $urandom_range(base - base / 50, base + base / 50);
  endfunction

  function automatic int unsigned below_floor();
    return ($urandom_range(0, 3) == 0) ? rpm_floor - 1 : $urandom_range(0, rpm_floor - 1);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got, want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("%0t: result %0d: %s got %0d, expected %0d", $realtime, result_count, what,
               got, want);
  endtask

  task automatic check_field(input string what, input int unsigned got, want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    result_count++;
    if (pending_actions.size() == 0) begin
      report_mismatch("result with no event pending, out_valid", 1, 0);
      return;
    end
    want = pending_actions.pop_front();
    check_field("coil_open", got.coil_open, want.coil_open);
    check_field("coil_close_now", got.coil_close_now, want.coil_close_now);
    check_field("coil_close_later", got.coil_close_later, want.coil_close_later);
    check_field("close_delay_deg", got.close_delay_deg, want.close_delay_deg);
    check_field("coil_mask", got.coil_mask, want.coil_mask);
    check_field("injector_open", got.injector_open, want.injector_open);
    check_field("injector_mask", got.injector_mask, want.injector_mask);
    check_field("injector_pulse_us", got.injector_pulse_us, want.injector_pulse_us);
    check_field("phase_state", got.phase_state, want.phase_state);
  endtask

  // result side: checks every transfer, stalls in random modes, and runs
  // the long hold when a test asks for it
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_item);
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(8, 64);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 30;
          3:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      mode_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_event(input in_item_t ev);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0 && !no_gaps) begin
        in_valid <= 1'b0;
        in_item  <= 18'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_actions.push_back(predict_actions(ev));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    in_item  <= 18'($urandom);
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_ADVANCE_ENABLE: adv_en  = val[0];
      CFG_ADVANCE_DEG:    adv_deg = val[ADV_W-1:0];
      CFG_FUEL_PULSE_MS:  fuel_ms = val;
      CFG_TRIM_ENABLE:    trim_en = val[0];
      default: ;
    endcase
  endtask

  task automatic write_regs(input logic [7:0] en, deg, fuel, trim);
    wait_idle();
    put_reg(CFG_ADVANCE_ENABLE, en);
    put_reg(CFG_ADVANCE_DEG, deg);
    put_reg(CFG_FUEL_PULSE_MS, fuel);
    put_reg(CFG_TRIM_ENABLE, trim);
    cfg_we <= 1'b0;
  endtask

  // one event of a well-formed crank sequence, now and then preceded by a
  // stray event or dropped as a missed tooth
  task automatic send_tooth(input logic [1:0] kind, input int unsigned slot, rpm);
    int unsigned stray_kind;
    int unsigned stray_slot;
    if ($urandom_range(0, 15) == 0) begin
      stray_kind = $urandom_range(0, 3);
      stray_slot = $urandom_range(0, 3);
      // strays never clock the phase search
      if (stray_kind == REQ_BTDC0 && stray_slot == 0) stray_slot = $urandom_range(1, 3);
      send_event(make_event(stray_kind, stray_slot, $urandom_range(0, RPM_MAX)));
    end
    if ($urandom_range(0, 31) != 0 || (kind == REQ_BTDC0 && slot == 0))
      send_event(make_event(kind, slot, rpm));
  endtask

  // two crank turns: three events per TDC slot; rpm0 goes with slot-0 BTDC0
  task automatic engine_cycle(input int unsigned rpm0, base);
    for (int s = 0; s < SLOTS; s++) begin
      send_tooth(REQ_BTDC140, s, near_rpm(base));
      send_tooth(REQ_BTDC10, s, near_rpm(base));
      send_tooth(REQ_BTDC0, s, (s == 0) ? rpm0 : near_rpm(base));
    end
  endtask

  task automatic test_directed();
    send_event(make_event(REQ_BTDC140, 0, 0));
    send_event(make_event(REQ_BTDC10, 1, RPM_MAX));
    send_event(make_event(REQ_BTDC0, 2, 14'h2AAA));
    send_event(make_event(REQ_UNUSED, 3, 14'h1555));
    // upper data bits must be dropped by the register widths
    write_regs(8'hFF, 8'h00, 8'hFF, 8'hFE);
    for (int s = 0; s < SLOTS; s++) send_event(make_event(REQ_BTDC10, s, RPM_MAX));
    send_event(make_event(REQ_BTDC140, 3, RPM_MAX));
    send_event(make_event(REQ_BTDC0, 0, 0));
    send_event(make_event(REQ_BTDC0, 3, RPM_MAX));
    // advance past the legal range
    write_regs(8'h01, 8'hFF, 8'h01, 8'h00);
    send_event(make_event(REQ_BTDC140, 1, 14'h0F0F));
    send_event(make_event(REQ_BTDC10, 2, 14'h30F0));
    send_event(make_event(REQ_BTDC0, 1, 0));
    send_event(make_event(REQ_UNUSED, 0, RPM_MAX));
    write_regs(8'h01, 8'd30, 8'h00, 8'h00);
    send_event(make_event(REQ_BTDC140, 2, 100));
    send_event(make_event(REQ_BTDC0, 0, 200));
    write_regs(8'h00, 8'd30, 8'd128, 8'h00);
    send_event(make_event(REQ_BTDC140, 0, 1));
    send_event(make_event(REQ_BTDC10, 3, 2));
    send_event(make_event(REQ_BTDC0, 2, 3));
  endtask

  task automatic test_config_sweep();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_regs(8'h00, 8'h00, 8'h00, 8'hFE);
        1: write_regs(8'h01, 8'h00, 8'hFF, 8'h00);
        2: write_regs(8'h01, 8'h1F, 8'h01, 8'h00);
        3: write_regs(8'h01, 8'd30, 8'($urandom), 8'h00);
        4: write_regs(8'hFE, 8'($urandom_range(1, 29)), 8'($urandom), 8'h00);
        default: write_regs(8'($urandom) | 8'h01, 8'($urandom), 8'($urandom),
                            8'($urandom) & 8'hFE);
      endcase
      repeat (70) send_event(random_event());
    end
  endtask

  // receiver holds off while the sender keeps offering, so the queue fills
  task automatic test_backpressure();
    write_regs(8'h01, 8'($urandom_range(0, 31)), 8'($urandom), 8'h00);
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    repeat (48) send_event(random_event());
    no_gaps = 1'b0;
  endtask

  task automatic test_phase_discovery();
    int unsigned base;
    int unsigned rpm0;
    int unsigned drop_turn;
    int unsigned low_turns;
    bit          lose_lock;
    bit          paused;
    logic [7:0]  en;
    logic [7:0]  deg;
    logic [7:0]  fuel;
    base      = $urandom_range(1200, 16000);
    lose_lock = $urandom_range(0, 1);
    drop_turn = $urandom_range(0, HOLD_TURNS - 1);
    low_turns = $urandom_range(0, 3);
    paused    = 1'b0;
    en        = 8'($urandom_range(0, 1));
    deg       = 8'($urandom_range(0, 30));
    fuel      = 8'($urandom);
    write_regs(en, deg, fuel, 8'h01);
    while (phase != PH_DONE) begin
      rpm0 = near_rpm(base);
      case (phase)
        PH_AVG: begin
          // trimming switched off halfway through the average: must pause
          if (!paused && phase_cnt == AVG_SAMPLES / 2) begin
            paused = 1'b1;
            write_regs(en, deg, fuel, 8'h00);
            repeat (2) engine_cycle($urandom_range(0, RPM_MAX), base);
            write_regs(en, deg, fuel, 8'h01);
          end
        end
        PH_HOLD: begin
          if (lose_lock && phase_cnt >= drop_turn) rpm0 = below_floor();
          else if ($urandom_range(0, 3) == 0) rpm0 = rpm_floor;
        end
        PH_LOST: begin
          if (low_turns != 0) begin
            low_turns--;
            rpm0 = below_floor();
          end
        end
        default: ;
      endcase
      engine_cycle(rpm0, base);
    end
    repeat (2) engine_cycle(near_rpm(base), base);
  endtask

  task automatic test_sequential_firing();
    int unsigned base;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       write_regs(8'h01, 8'h1F, 8'($urandom), 8'h01);
        1:       write_regs(8'h01, 8'h00, 8'hFF, 8'h00);
        default: write_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      base = $urandom_range(0, 16000);
      repeat (8) engine_cycle($urandom_range(0, RPM_MAX), base);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_phase_discovery();
    test_sequential_firing();
    in_valid <= 1'b0;
    for (int n = 0; n < 5000 && pending_actions.size() != 0; n++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_actions.size() != 0)
      report_mismatch("events left without a result, count", pending_actions.size(), 0);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
